FILE: hdl/evfd_pkg.sv
package evfd_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// reset value of the discard mask: the discardable type bit
	localparam logic [31:0] DISCARD_MASK_RESET = 32'h8000_0000;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [2:0] ST_ENQ         = 3'd0;
	localparam logic [2:0] ST_ENQ_DISCARD = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_DEQ         = 3'd3;
	localparam logic [2:0] ST_EMPTY       = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [31:0] event_type;
		logic [31:0] event_data;
		logic [31:0] release_handle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_type;
		logic [31:0] out_data;
		logic [31:0] out_release;
		logic [31:0] dropped_data;
		logic [31:0] dropped_release;
	} out_item_t;

	typedef struct packed {
		logic [31:0] etype;
		logic [31:0] edata;
		logic [31:0] erel;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_entry;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} store_req_t;

endpackage

FILE: hdl/evfd_store.sv
module evfd_store (
	input  logic                clk,
	input  evfd_pkg::store_req_t req,
	output evfd_pkg::entry_t     rd_entry
);
	import evfd_pkg::*;

	logic [31:0] type_mem [CAPACITY];
	logic [31:0] data_mem [CAPACITY];
	logic [31:0] rel_mem  [CAPACITY];
	entry_t      rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			type_mem[req.wr_addr] <= req.wr_entry.etype;
			data_mem[req.wr_addr] <= req.wr_entry.edata;
			rel_mem[req.wr_addr]  <= req.wr_entry.erel;
		end
		if (req.rd_en) begin
			rd_q.etype <= type_mem[req.rd_addr];
			rd_q.edata <= data_mem[req.rd_addr];
			rd_q.erel  <= rel_mem[req.rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

FILE: hdl/evfd_seq.sv
module evfd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          mask,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  evfd_pkg::in_item_t   in_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output evfd_pkg::out_item_t  res_item,
	output evfd_pkg::store_req_t st_req,
	input  evfd_pkg::entry_t     st_rd
);
	import evfd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EQ_POP = 8'b0000_0010,
		S_EQ_APP = 8'b0000_0100,
		S_DQ_FIN = 8'b0000_1000,
		S_SC_CMP = 8'b0001_0000,
		S_FX1    = 8'b0010_0000,
		S_FX2    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] head_q, tail_q, cur_q, slot_q, n_q;
	logic [CNT_W-1:0] count_q, fsp_q, fresh_q;
	in_item_t         item_q;
	out_item_t        res_q;
	out_item_t        res_init;

	// link memories and free-slot stack
	logic [IDX_W-1:0] nxt_mem [CAPACITY];
	logic [IDX_W-1:0] prv_mem [CAPACITY];
	logic [IDX_W-1:0] fstk_mem [CAPACITY];
	logic [IDX_W-1:0] nxt_rd_q, prv_rd_q, fstk_rd_q;

	logic             nw_en, nr_en, pw_en, pr_en, fw_en, fr_en;
	logic [IDX_W-1:0] nw_addr, nw_data, nr_addr, pw_addr, pw_data, pr_addr;
	logic [IDX_W-1:0] fw_addr, fw_data, fr_addr;

	logic             accept, is_full, hit, last_step;
	logic [IDX_W-1:0] fsp_top;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign hit       = |(st_rd.etype & mask);  // the shared compare unit
	assign last_step = (n_q == IDX_W'(CAPACITY - 1));
	assign fsp_top   = fsp_q[IDX_W-1:0] - IDX_W'(1);
	assign res_valid = (state_q == S_DONE);
	assign res_item  = res_q;

	always_comb begin
		res_init = '0;
		if (in_item.operation == OP_DEQ && count_q == '0)
			res_init.status = ST_EMPTY;
	end

	always_ff @(posedge clk) begin
		if (nw_en)
			nxt_mem[nw_addr] <= nw_data;
		if (nr_en)
			nxt_rd_q <= nxt_mem[nr_addr];
		if (pw_en)
			prv_mem[pw_addr] <= pw_data;
		if (pr_en)
			prv_rd_q <= prv_mem[pr_addr];
		if (fw_en)
			fstk_mem[fw_addr] <= fw_data;
		if (fr_en)
			fstk_rd_q <= fstk_mem[fr_addr];
	end

	always_comb begin
		st_req  = '0;
		nw_en   = 1'b0;
		nw_addr = '0;
		nw_data = '0;
		nr_en   = 1'b0;
		nr_addr = '0;
		pw_en   = 1'b0;
		pw_addr = '0;
		pw_data = '0;
		pr_en   = 1'b0;
		pr_addr = '0;
		fw_en   = 1'b0;
		fw_addr = '0;
		fw_data = '0;
		fr_en   = 1'b0;
		fr_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_item.operation == OP_DEQ) begin
						st_req.rd_en   = (count_q != '0);
						st_req.rd_addr = head_q;
						nr_en          = (count_q != '0);
						nr_addr        = head_q;
					end else if (is_full) begin
						st_req.rd_en   = 1'b1;
						st_req.rd_addr = head_q;
						nr_en          = 1'b1;
						nr_addr        = head_q;
						pr_en          = 1'b1;
						pr_addr        = head_q;
					end else begin
						fr_en   = (fsp_q != '0);
						fr_addr = fsp_top;
					end
				end
			end
			S_SC_CMP: begin
				if (!hit && !last_step) begin
					st_req.rd_en   = 1'b1;
					st_req.rd_addr = nxt_rd_q;
					nr_en          = 1'b1;
					nr_addr        = nxt_rd_q;
					pr_en          = 1'b1;
					pr_addr        = nxt_rd_q;
				end
			end
			S_FX1: begin
				// unlink the victim
				nw_en   = (cur_q != head_q);
				nw_addr = prv_rd_q;
				nw_data = nxt_rd_q;
				pw_en   = (cur_q != tail_q);
				pw_addr = nxt_rd_q;
				pw_data = prv_rd_q;
			end
			S_FX2: begin
				// victim's slot takes the new word at the tail
				nw_en                   = 1'b1;
				nw_addr                 = tail_q;
				nw_data                 = cur_q;
				pw_en                   = 1'b1;
				pw_addr                 = cur_q;
				pw_data                 = tail_q;
				st_req.wr_en            = 1'b1;
				st_req.wr_addr          = cur_q;
				st_req.wr_entry.etype   = item_q.event_type;
				st_req.wr_entry.edata   = item_q.event_data;
				st_req.wr_entry.erel    = item_q.release_handle;
			end
			S_EQ_APP: begin
				nw_en                   = (count_q != '0);
				nw_addr                 = tail_q;
				nw_data                 = slot_q;
				pw_en                   = 1'b1;
				pw_addr                 = slot_q;
				pw_data                 = tail_q;
				st_req.wr_en            = 1'b1;
				st_req.wr_addr          = slot_q;
				st_req.wr_entry.etype   = item_q.event_type;
				st_req.wr_entry.edata   = item_q.event_data;
				st_req.wr_entry.erel    = item_q.release_handle;
			end
			S_DQ_FIN: begin
				fw_en   = 1'b1;
				fw_addr = fsp_q[IDX_W-1:0];
				fw_data = head_q;
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= in_item;
					res_q  <= res_init;
					cur_q  <= head_q;
					slot_q <= fresh_q[IDX_W-1:0];
				end
			end
			S_EQ_POP: slot_q <= fstk_rd_q;
			S_EQ_APP: res_q.status <= ST_ENQ;
			S_DQ_FIN: begin
				res_q.status      <= ST_DEQ;
				res_q.out_type    <= st_rd.etype;
				res_q.out_data    <= st_rd.edata;
				res_q.out_release <= st_rd.erel;
			end
			S_SC_CMP: begin
				if (hit) begin
					res_q.status          <= ST_ENQ_DISCARD;
					res_q.dropped_data    <= st_rd.edata;
					res_q.dropped_release <= st_rd.erel;
				end else if (last_step) begin
					res_q.status <= ST_FULL;
				end else begin
					cur_q <= nxt_rd_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fsp_q   <= '0;
			fresh_q <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q <= '0;
						if (in_item.operation == OP_DEQ)
							state_q <= (count_q == '0) ? S_DONE : S_DQ_FIN;
						else if (is_full)
							state_q <= S_SC_CMP;
						else if (fsp_q != '0)
							state_q <= S_EQ_POP;
						else begin
							fresh_q <= fresh_q + CNT_W'(1);
							state_q <= S_EQ_APP;
						end
					end
				end
				S_EQ_POP: begin
					fsp_q   <= fsp_q - CNT_W'(1);
					state_q <= S_EQ_APP;
				end
				S_EQ_APP: begin
					if (count_q == '0)
						head_q <= slot_q;
					tail_q  <= slot_q;
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DQ_FIN: begin
					head_q  <= nxt_rd_q;
					count_q <= count_q - CNT_W'(1);
					fsp_q   <= fsp_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SC_CMP: begin
					if (hit)
						state_q <= S_FX1;
					else if (last_step)
						state_q <= S_DONE;
					else
						n_q <= n_q + IDX_W'(1);
				end
				S_FX1: begin
					if (cur_q == head_q)
						head_q <= nxt_rd_q;
					if (cur_q == tail_q)
						tail_q <= prv_rd_q;
					state_q <= S_FX2;
				end
				S_FX2: begin
					tail_q  <= cur_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/event_fifo_with_discard_core.sv
// Bounded event queue of evfd_pkg::CAPACITY entries kept as a doubly linked list in
// on-chip memories. Each accepted word gives exactly one result word. A dequeue reads
// the head entry on acceptance and finishes in S_DQ_FIN, or goes straight to the result
// when the queue is empty; an enqueue into a queue that is not full appends in S_EQ_APP,
// after S_EQ_POP when a freed slot is popped from the free-slot stack. When the queue
// is full the victim search walks the list from the head through one type-and-mask
// compare per cycle; the first discardable entry is relinked in S_FX1 and S_FX2, and
// the search covers every entry when nothing can be dropped. A new word is taken
// only while the sequencer is idle; a finished result may still be waiting in the
// output register. The discard mask resets to the discardable type bit and should be
// written only while the block is idle. No clearing pass is needed after reset.
module event_fifo_with_discard_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  evfd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output evfd_pkg::out_item_t out_item
);
	import evfd_pkg::*;

	logic        [31:0] mask_q;
	logic               res_valid, res_ready;
	out_item_t          res_item;
	store_req_t         st_req;
	entry_t             st_rd;
	logic               out_valid_q;
	out_item_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= DISCARD_MASK_RESET;
		else if (cfg_wr_en)
			mask_q <= cfg_wr_data;
	end

	evfd_store u_store (
		.clk      (clk),
		.req      (st_req),
		.rd_entry (st_rd)
	);

	evfd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.mask      (mask_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.st_req    (st_req),
		.st_rd     (st_rd)
	);

	// output register: frees the sequencer while a result word waits downstream
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res_item;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_idle_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("sequencer idle with a result pending");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_EMPTY)
		else $error("status code out of range");

	a_deq_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_DEQ |->
			out_item.out_type == '0 && out_item.out_data == '0 &&
			out_item.out_release == '0)
		else $error("dequeue fields set on a non-dequeue result");

endmodule
